>>> sv/sliding_window_mean_top_defines.svh
// Assertion macros shared by the sliding window mean RTL.
`ifndef SLIDING_WINDOW_MEAN_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEAN_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swm same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swm next-cycle check failed");

`endif

>>> sv/swm_pkg.sv
// Types, constants and helper functions of the sliding window mean block.
package swm_pkg;

    localparam int WINDOW_MAX  = 256;
    localparam int SLOT_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W       = $clog2(WINDOW_MAX + 1);
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int VALUE_W     = 32;
    localparam int TIME_W      = 63;
    localparam int SUM_W       = 40;
    localparam int MEAN_W      = 42;
    localparam int FRAC_W      = 16;
    localparam int SCALE       = 100;
    localparam int DIV_W       = $clog2(SCALE * WINDOW_MAX + 1);
    localparam int NUM_W       = SUM_W + FRAC_W;
    localparam int CNT_W       = $clog2(NUM_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BACKWARD_STAMP = CFG_IDX_W'(1);

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic [TIME_W-1:0]         sample_time;
        logic                      restart;
    } swm_in_t;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean_value;
        logic [TIME_W-1:0]        window_time;
    } swm_out_t;

    // One division job handed from the front to the back.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [DIV_W-1:0]        divisor;
        logic [TIME_W-1:0]       stamp;
    } swm_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } swm_qstat_t;

    // A zero length acts as one, and a length above the ring size saturates.
    function automatic logic [LEN_W-1:0] clamp_length(input logic [CFG_W-1:0] raw);
        int unsigned r;
        r = 32'(raw);
        if (r == 0)
        begin
            r = 1;
        end
        if (r > WINDOW_MAX)
        begin
            r = WINDOW_MAX;
        end
        return LEN_W'(r);
    endfunction

endpackage

>>> sv/swm_queue.sv
// Short job queue between the front and the back of the sliding window mean.
`include "sliding_window_mean_top_defines.svh"

module swm_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  swm_pkg::swm_job_t  job_in,
    input  logic               pop,
    output swm_pkg::swm_job_t  job_out,
    output swm_pkg::swm_qstat_t qstat
);

    swm_pkg::swm_job_t entries_reg [swm_pkg::QUEUE_DEPTH];

    logic [swm_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [swm_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [swm_pkg::QCNT_W-1:0] count_reg, count_next;

    function automatic logic [swm_pkg::QPTR_W-1:0] ptr_inc(input logic [swm_pkg::QPTR_W-1:0] p);
        if (p == swm_pkg::QPTR_W'(swm_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign qstat.full  = (count_reg == swm_pkg::QCNT_W'(swm_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign job_out     = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= job_in;
        end
    end

    `SWM_ASSERT_NOW(a_no_push_when_full, clk, rst_n, push, !qstat.full)
    `SWM_ASSERT_NOW(a_no_pop_when_empty, clk, rst_n, pop, !qstat.empty)

endmodule

>>> sv/swm_front.sv
// Front of the sliding window mean: sample intake, rings, running sum, job issue.
`include "sliding_window_mean_top_defines.svh"

module swm_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  swm_pkg::swm_in_t                  sample,
    input  logic                              cfg_we,
    input  logic [swm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swm_pkg::CFG_W-1:0]         cfg_data,
    input  swm_pkg::swm_qstat_t               qstat,
    output logic                              push,
    output swm_pkg::swm_job_t                 job
);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_CALC = 2'b10
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [swm_pkg::LEN_W-1:0]          len_reg;
    logic                               backward_reg;
    logic [swm_pkg::LEN_W-1:0]          fill_reg;
    logic signed [swm_pkg::SUM_W-1:0]   sum_reg;
    logic [swm_pkg::SLOT_W-1:0]         slot_reg;

    swm_pkg::swm_in_t                   item_reg;
    logic signed [swm_pkg::VALUE_W-1:0] old_value_reg;
    logic [swm_pkg::TIME_W-1:0]         old_time_reg;

    logic signed [swm_pkg::VALUE_W-1:0] value_ring [swm_pkg::WINDOW_MAX];
    logic [swm_pkg::TIME_W-1:0]         time_ring  [swm_pkg::WINDOW_MAX];

    logic                               accept;
    logic [swm_pkg::LEN_W:0]            slot_ext;
    logic [swm_pkg::LEN_W:0]            len_ext;
    logic [swm_pkg::SLOT_W-1:0]         leave_idx;
    logic [swm_pkg::SLOT_W-1:0]         oldest_idx;
    logic [swm_pkg::SLOT_W-1:0]         slot_next;
    logic [swm_pkg::LEN_W-1:0]          fill_eff;
    logic [swm_pkg::LEN_W-1:0]          fill_new;
    logic signed [swm_pkg::SUM_W-1:0]   sum_eff;
    logic signed [swm_pkg::SUM_W-1:0]   sum_new;
    logic signed [swm_pkg::VALUE_W:0]   delta;
    logic                               window_full;
    logic [swm_pkg::LEN_W-1:0]          len_cfg;

    assign sample_stall = !((state_reg == F_IDLE) && !qstat.full);
    assign accept       = sample_valid && !sample_stall;

    // Ring positions relative to the next write slot.
    always_comb
    begin
        slot_ext = (swm_pkg::LEN_W + 1)'(slot_reg);
        len_ext  = (swm_pkg::LEN_W + 1)'(len_reg);
        if (slot_ext >= len_ext)
        begin
            leave_idx = swm_pkg::SLOT_W'(slot_ext - len_ext);
        end
        else
        begin
            leave_idx = swm_pkg::SLOT_W'(slot_ext
                        + (swm_pkg::LEN_W + 1)'(swm_pkg::WINDOW_MAX) - len_ext);
        end
        if (leave_idx == swm_pkg::SLOT_W'(swm_pkg::WINDOW_MAX - 1))
        begin
            oldest_idx = '0;
        end
        else
        begin
            oldest_idx = leave_idx + 1'b1;
        end
        if (slot_reg == swm_pkg::SLOT_W'(swm_pkg::WINDOW_MAX - 1))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + 1'b1;
        end
    end

    // Window update for the latched sample.
    always_comb
    begin
        fill_eff    = item_reg.restart ? '0 : fill_reg;
        sum_eff     = item_reg.restart ? '0 : sum_reg;
        window_full = (fill_eff >= len_reg);
        delta = {item_reg.sample_value[swm_pkg::VALUE_W-1], item_reg.sample_value}
              - (window_full ? {old_value_reg[swm_pkg::VALUE_W-1], old_value_reg}
                             : '0);
        sum_new  = sum_eff + swm_pkg::SUM_W'(delta);
        fill_new = window_full ? fill_eff : fill_eff + 1'b1;
    end

    assign push = (state_reg == F_CALC) && (fill_new == len_reg);

    // With a window of one the oldest entry is the sample being written now.
    always_comb
    begin
        job.sum     = sum_new;
        job.divisor = swm_pkg::DIV_W'(32'(len_reg) * swm_pkg::SCALE);
        if (backward_reg && (len_reg != swm_pkg::LEN_W'(1)))
        begin
            job.stamp = old_time_reg;
        end
        else
        begin
            job.stamp = item_reg.sample_time;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_CALC;
                end
            end
            F_CALC:
            begin
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign len_cfg = swm_pkg::clamp_length(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            len_reg      <= swm_pkg::LEN_W'(1);
            backward_reg <= 1'b0;
            fill_reg     <= '0;
            sum_reg      <= '0;
            slot_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_CALC)
            begin
                fill_reg <= fill_new;
                sum_reg  <= sum_new;
                slot_reg <= slot_next;
            end
            else if (cfg_we)
            begin
                if (cfg_index == swm_pkg::REG_WINDOW_LENGTH)
                begin
                    // A new effective length empties the window.
                    if (len_cfg != len_reg)
                    begin
                        len_reg  <= len_cfg;
                        fill_reg <= '0;
                        sum_reg  <= '0;
                    end
                end
                else if (cfg_index == swm_pkg::REG_BACKWARD_STAMP)
                begin
                    backward_reg <= cfg_data[0];
                end
            end
        end
    end

    // Reads sample the ring every cycle; the values taken at the accept edge
    // are the ones used while the sample is processed.
    always_ff @(posedge clk)
    begin
        old_value_reg <= value_ring[leave_idx];
        old_time_reg  <= time_ring[oldest_idx];
        if (accept)
        begin
            item_reg <= sample;
        end
        if (state_reg == F_CALC)
        begin
            value_ring[slot_reg] <= item_reg.sample_value;
            time_ring[slot_reg]  <= item_reg.sample_time;
        end
    end

    `SWM_ASSERT_NOW(a_fill_bounded, clk, rst_n, 1'b1, fill_reg <= len_reg)
    `SWM_ASSERT_NOW(a_calc_has_room, clk, rst_n, state_reg == F_CALC, !qstat.full)

endmodule

>>> sv/swm_back.sv
// Back of the sliding window mean: serial divider and result register.
`include "sliding_window_mean_top_defines.svh"

module swm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  swm_pkg::swm_qstat_t qstat,
    input  swm_pkg::swm_job_t   job,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output swm_pkg::swm_out_t   result
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_DONE = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [swm_pkg::CNT_W-1:0]  cnt_reg;
    logic [swm_pkg::NUM_W-1:0]  num_reg;
    logic [swm_pkg::DIV_W-1:0]  rem_reg;
    logic [swm_pkg::DIV_W-1:0]  div_reg;
    logic                       neg_reg;
    logic [swm_pkg::TIME_W-1:0] stamp_reg;
    logic                       res_valid_reg;
    swm_pkg::swm_out_t          res_reg;

    logic [swm_pkg::DIV_W:0]    rem_sh;
    logic [swm_pkg::DIV_W:0]    rem_sub;
    logic                       rem_ge;
    logic [swm_pkg::DIV_W-1:0]  rem_step;
    logic [swm_pkg::SUM_W-1:0]  mag;
    logic [swm_pkg::MEAN_W-1:0] quot;
    logic                       take;
    logic                       last_step;

    assign pop  = (state_reg == B_IDLE) && !qstat.empty;
    assign take = !res_valid_reg || !result_stall;
    assign last_step = (cnt_reg == swm_pkg::CNT_W'(swm_pkg::NUM_W - 1));

    // One restoring step: the remainder always stays below the divisor.
    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[swm_pkg::NUM_W-1]};
        rem_sub  = rem_sh - {1'b0, div_reg};
        rem_ge   = (rem_sh >= {1'b0, div_reg});
        rem_step = rem_ge ? swm_pkg::DIV_W'(rem_sub) : swm_pkg::DIV_W'(rem_sh);
    end

    assign mag  = job.sum[swm_pkg::SUM_W-1] ? swm_pkg::SUM_W'(-job.sum)
                                            : swm_pkg::SUM_W'(job.sum);
    assign quot = num_reg[swm_pkg::MEAN_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (last_step)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (take)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
            if ((state_reg == B_DONE) && take)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            num_reg   <= {mag, swm_pkg::FRAC_W'(0)};
            rem_reg   <= '0;
            div_reg   <= job.divisor;
            neg_reg   <= job.sum[swm_pkg::SUM_W-1];
            stamp_reg <= job.stamp;
        end
        else if (state_reg == B_DIV)
        begin
            num_reg <= {num_reg[swm_pkg::NUM_W-2:0], rem_ge};
            rem_reg <= rem_step;
        end
        if ((state_reg == B_DONE) && take)
        begin
            res_reg.mean_value  <= neg_reg ? -quot : quot;
            res_reg.window_time <= stamp_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    `SWM_ASSERT_NEXT(a_done_lands, clk, rst_n, (state_reg == B_DONE) && take, res_valid_reg)
    `SWM_ASSERT_NOW(a_div_count, clk, rst_n, state_reg == B_IDLE, cnt_reg == '0)

endmodule

>>> sv/sliding_window_mean_top.sv
// Top level of the sliding window mean block.
//
//   channel   direction  handshake                    payload
//   sample    in         sample_valid / sample_stall  swm_in_t
//   result    out        result_valid / result_stall  swm_out_t
//   config    in         cfg_we                       cfg_index, cfg_data
//
// The front takes a new sample only once the last one is done and the job
// queue has room. The back works out each result with a 56-step serial
// divider; a two-entry queue and the result register decouple both sides.
// Reset clears the window, the registers and the queue; ring contents are
// not cleared and are read only after being written since the last restart.
// A stalled result holds in its register while the divider works on the next.
module sliding_window_mean_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  swm_pkg::swm_in_t              sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output swm_pkg::swm_out_t             result,
    input  logic                          cfg_we,
    input  logic [swm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swm_pkg::CFG_W-1:0]     cfg_data
);

    swm_pkg::swm_qstat_t qstat;
    swm_pkg::swm_job_t   job_push;
    swm_pkg::swm_job_t   job_head;
    logic                push;
    logic                pop;

    swm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .qstat        (qstat),
        .push         (push),
        .job          (job_push)
    );

    swm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_push),
        .pop     (pop),
        .job_out (job_head),
        .qstat   (qstat)
    );

    swm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .job          (job_head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

>>> dv/sliding_window_mean_top_test.sv
// Self-checking testbench of the sliding window mean block, with its own window predictor.
module sliding_window_mean_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swm_pkg::*;

    localparam int RUN_LIMIT_NS  = 2000000;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 100;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
    localparam logic [TIME_W-1:0]         TIME_MAX  = '1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    swm_in_t              sample = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    swm_out_t             result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    sliding_window_mean_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    swm_in_t  pending_samples[$];
    swm_out_t expected_means[$];
    int       items_queued = 0;
    int       items_accepted = 0;
    int       mismatch_count = 0;
    logic     sample_taken = 1'b0;

    int       send_idle_pct = 0;
    int       stall_pct = 0;
    int       holds_requested = 0;
    int       holds_started = 0;
    int       hold_left = 0;

    // Predictor state.
    logic signed [VALUE_W-1:0] ring_value[WINDOW_MAX];
    logic [TIME_W-1:0]         ring_time[WINDOW_MAX];
    longint                    window_sum = 0;
    int unsigned               window_fill = 0;
    int unsigned               ring_slot = 0;
    int unsigned               window_len = 1;
    bit                        stamp_oldest = 1'b0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(string what);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        int unsigned len;
        if (idx == REG_WINDOW_LENGTH)
        begin
            len = 32'(data);
            if (len == 0)
            begin
                len = 1;
            end
            if (len > WINDOW_MAX)
            begin
                len = WINDOW_MAX;
            end
            // Only a change of the effective length empties the window.
            if (len != window_len)
            begin
                window_len  = len;
                window_fill = 0;
                window_sum  = 0;
            end
        end
        else if (idx == REG_BACKWARD_STAMP)
        begin
            stamp_oldest = data[0];
        end
    endfunction

    function automatic void predict_window_mean(swm_in_t s);
        int unsigned      leaving;
        int unsigned      oldest;
        longint unsigned  magnitude;
        longint unsigned  divisor;
        longint unsigned  quotient;
        swm_out_t         mean;
        if (s.restart)
        begin
            window_fill = 0;
            window_sum  = 0;
        end
        if (window_fill >= window_len)
        begin
            leaving = (ring_slot + WINDOW_MAX - window_len) % WINDOW_MAX;
            window_sum -= longint'(ring_value[leaving]);
        end
        else
        begin
            window_fill++;
        end
        window_sum += longint'(s.sample_value);
        ring_value[ring_slot] = s.sample_value;
        ring_time[ring_slot]  = s.sample_time;
        ring_slot = (ring_slot + 1) % WINDOW_MAX;
        if (window_fill >= window_len)
        begin
            oldest    = (ring_slot + WINDOW_MAX - window_len) % WINDOW_MAX;
            magnitude = (window_sum < 0) ? -window_sum : window_sum;
            divisor   = 64'(100 * window_len);
            quotient  = (magnitude << FRAC_W) / divisor;
            mean.mean_value  = (window_sum < 0) ? MEAN_W'(-quotient) : MEAN_W'(quotient);
            mean.window_time = stamp_oldest ? ring_time[oldest] : s.sample_time;
            expected_means.push_back(mean);
        end
    endfunction

    // Monitor: register writes, accepted samples and accepted results.
    always @(posedge clk)
    begin
        swm_out_t want;
        if (!rst_n)
        begin
            sample_taken <= 1'b0;
        end
        else
        begin
            sample_taken <= sample_valid && !sample_stall;
            if (cfg_we)
            begin
                apply_register(cfg_index, cfg_data);
            end
            if (result_valid && !result_stall)
            begin
                if (expected_means.size() == 0)
                begin
                    report_mismatch("result transaction with no expectation pending");
                end
                else
                begin
                    want = expected_means.pop_front();
                    if (result.mean_value !== want.mean_value)
                    begin
                        report_mismatch($sformatf("mean_value got %0d expected %0d",
                                                  result.mean_value, want.mean_value));
                    end
                    if (result.window_time !== want.window_time)
                    begin
                        report_mismatch($sformatf("window_time got %0d expected %0d",
                                                  result.window_time, want.window_time));
                    end
                end
            end
            if (sample_valid && !sample_stall)
            begin
                predict_window_mean(sample);
                items_accepted++;
            end
        end
    end

    // Sample driver: a transaction stays on the bus until it is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else if (!sample_valid || sample_taken)
        begin
            if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                sample       <= pending_samples.pop_front();
                sample_valid <= 1'b1;
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus long hold-offs on request.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if (holds_started != holds_requested)
        begin
            result_stall  <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            holds_started <= holds_started + 1;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return '0;
            3: return -1;
            4, 5: return int'($urandom_range(0, 20000)) - 10000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_stamp();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return TIME_MAX;
            default: return TIME_W'({$urandom, $urandom});
        endcase
    endfunction

    task automatic queue_sample(logic signed [VALUE_W-1:0] value, logic [TIME_W-1:0] stamp,
                                bit restart);
        swm_in_t s;
        s.sample_value = value;
        s.sample_time  = stamp;
        s.restart      = restart;
        pending_samples.push_back(s);
        items_queued++;
    endtask

    task automatic queue_random(int count, int restart_odds);
        repeat (count)
        begin
            queue_sample(pick_value(), pick_stamp(),
                         restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Waits until every sample is taken and every result has come, then lets
    // a sample that yields no result finish inside the block.
    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((items_accepted != items_queued || expected_means.size() != 0)
               && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        if (guard >= DRAIN_LIMIT)
        begin
            report_mismatch($sformatf("%0d results still outstanding", expected_means.size()));
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    initial
    begin
        foreach (ring_value[i])
        begin
            ring_value[i] = '0;
            ring_time[i]  = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Window of one after reset: field extremes, each sample gives a result.
        queue_sample(VALUE_MIN, '0, 1'b1);
        queue_sample(VALUE_MAX, TIME_MAX, 1'b0);
        queue_sample('0, TIME_W'(1), 1'b0);
        queue_sample(-1, TIME_W'(2), 1'b0);
        queue_sample(-100, TIME_W'(3), 1'b1);
        queue_sample(99, TIME_W'(4), 1'b0);
        queue_sample(1, TIME_W'(5), 1'b0);
        wait_idle();

        // Unknown indexes are ignored; a zero length acts as one and keeps the window.
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, '0);
        write_reg(REG_WINDOW_LENGTH, '0);
        queue_sample(12345, TIME_W'(7), 1'b0);
        wait_idle();

        write_reg(REG_WINDOW_LENGTH, CFG_W'(3));
        write_reg(REG_BACKWARD_STAMP, CFG_W'(1));
        queue_sample(300, TIME_W'(10), 1'b0);
        queue_sample(-700, TIME_W'(11), 1'b0);
        wait_idle();

        // Changing the stamp mode keeps a partly filled window.
        write_reg(REG_BACKWARD_STAMP, CFG_W'(0));
        queue_sample(1000, TIME_W'(12), 1'b0);
        queue_sample(VALUE_MIN, TIME_W'(13), 1'b0);
        queue_sample(VALUE_MIN, TIME_W'(14), 1'b1);
        queue_sample(5, TIME_W'(15), 1'b0);
        queue_sample(-5, TIME_W'(16), 1'b0);
        wait_idle();

        // Rewriting the same length keeps the window.
        write_reg(REG_WINDOW_LENGTH, CFG_W'(3));
        write_reg(REG_BACKWARD_STAMP, CFG_W'(1));
        queue_sample(VALUE_MAX, TIME_W'(17), 1'b0);
        queue_sample(-12345, TIME_W'(18), 1'b0);
        wait_idle();

        set_idling(0, 0);
        write_reg(REG_WINDOW_LENGTH, CFG_W'(1));
        write_reg(REG_BACKWARD_STAMP, CFG_W'(0));
        queue_random(80, 20);
        wait_idle();

        set_idling(51, 0);
        write_reg(REG_WINDOW_LENGTH, CFG_W'(3));
        write_reg(REG_BACKWARD_STAMP, CFG_W'(1));
        queue_random(80, 25);
        wait_idle();

        set_idling(0, 51);
        write_reg(REG_WINDOW_LENGTH, CFG_W'(7));
        write_reg(REG_BACKWARD_STAMP, CFG_W'(0));
        queue_random(80, 40);
        wait_idle();

        set_idling(30, 30);
        write_reg(REG_WINDOW_LENGTH, CFG_W'(2));
        write_reg(REG_BACKWARD_STAMP, CFG_W'(1));
        queue_random(80, 20);
        wait_idle();

        // Largest window filled with the most negative value: the lowest mean.
        set_idling(0, 0);
        write_reg(REG_WINDOW_LENGTH, CFG_W'(WINDOW_MAX));
        repeat (WINDOW_MAX) queue_sample(VALUE_MIN, pick_stamp(), 1'b0);
        queue_random(14, 0);
        wait_idle();

        // An oversized length saturates to the same window, which stays full.
        write_reg(REG_WINDOW_LENGTH, '1);
        write_reg(REG_BACKWARD_STAMP, CFG_W'(0));
        queue_random(10, 0);
        wait_idle();

        // Long receiver hold-off while samples keep coming, so the input backs up.
        write_reg(REG_WINDOW_LENGTH, CFG_W'(16));
        holds_requested++;
        queue_random(40, 0);
        wait_idle();
        set_idling(30, 30);
        queue_random(40, 30);
        wait_idle();

        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/swm_pkg.sv
sv/swm_queue.sv
sv/swm_front.sv
sv/swm_back.sv
sv/sliding_window_mean_top.sv
dv/sliding_window_mean_top_test.sv
